@@ src/sbf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sbf_pkg;

	localparam int STORE_BYTES_DEF = 4096;
	localparam int LINE_LIMIT_DEF  = 64;
	localparam int COL_LIMIT_DEF   = 255;

	localparam int BYTE_W        = 8;
	localparam int OP_W          = 2;
	localparam int MAX_LINES_W   = 7;
	localparam int MAX_COLS_W    = 8;
	localparam int CFG_DATA_W    = 8;
	localparam int CFG_IDX_W     = 1;
	localparam int COL_W         = 13;
	localparam int TOTAL_W       = 32;

	localparam logic [BYTE_W-1:0] NEWLINE   = 8'd10;
	localparam logic [BYTE_W-1:0] ZERO_CHAR = 8'd48;
	localparam logic [COL_W-1:0]  MIN_FOLD  = 13'd3;
	localparam logic [COL_W-1:0]  COL_MAX   = 13'd8191;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_COLS  = 1'd1;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_READ   = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_PUT,
		ST_DROP_RD,
		ST_DROP,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

@@ src/sbf_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface sbf_in_if #(
	parameter int IDX_W = $clog2(sbf_pkg::STORE_BYTES_DEF)
);
	logic                        valid;
	logic                        ready;
	logic [sbf_pkg::OP_W-1:0]    operation;
	logic [sbf_pkg::BYTE_W-1:0]  byte_value;
	logic [IDX_W-1:0]            index;
	logic                        last_of_write;

	modport source (output valid, operation, byte_value, index, last_of_write, input ready);
	modport sink (input valid, operation, byte_value, index, last_of_write, output ready);
endinterface

interface sbf_out_if #(
	parameter int LEN_W  = $clog2(sbf_pkg::STORE_BYTES_DEF + 1),
	parameter int LCNT_W = $clog2(sbf_pkg::LINE_LIMIT_DEF + 1)
);
	logic                         valid;
	logic                         ready;
	logic [sbf_pkg::BYTE_W-1:0]   read_byte;
	logic [LEN_W-1:0]             text_length;
	logic [LEN_W-1:0]             new_bytes;
	logic [LCNT_W-1:0]            line_count;
	logic                         overflowed;
	logic [sbf_pkg::TOTAL_W-1:0]  total_bytes;
	logic                         status;

	modport source (output valid, read_byte, text_length, new_bytes, line_count, overflowed,
		total_bytes, status, input ready);
	modport sink (input valid, read_byte, text_length, new_bytes, line_count, overflowed,
		total_bytes, status, output ready);
endinterface

`default_nettype wire

@@ src/sbf_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sbf_ram #(
	parameter int DEPTH = sbf_pkg::STORE_BYTES_DEF,
	parameter int WIDTH = sbf_pkg::BYTE_W
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ src/sbf_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sbf_ctrl #(
	parameter int STORE_BYTES = sbf_pkg::STORE_BYTES_DEF,
	parameter int LINE_LIMIT  = sbf_pkg::LINE_LIMIT_DEF,
	parameter int COL_LIMIT   = sbf_pkg::COL_LIMIT_DEF,
	localparam int IDX_W      = $clog2(STORE_BYTES),
	localparam int QD         = LINE_LIMIT + 1,
	localparam int QA_W       = $clog2(QD)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [sbf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [sbf_pkg::CFG_DATA_W-1:0]    cfg_data,
	sbf_in_if.sink                                 item,
	sbf_out_if.source                              res,
	output logic                                   t_we,
	output logic      [IDX_W-1:0]                  t_waddr,
	output logic      [sbf_pkg::BYTE_W-1:0]        t_wdata,
	output logic                                   t_re,
	output logic      [IDX_W-1:0]                  t_raddr,
	input  wire logic [sbf_pkg::BYTE_W-1:0]        t_rdata,
	output logic                                   q_we,
	output logic      [QA_W-1:0]                   q_waddr,
	output logic      [IDX_W-1:0]                  q_wdata,
	output logic                                   q_re,
	output logic      [QA_W-1:0]                   q_raddr,
	input  wire logic [IDX_W-1:0]                  q_rdata
);

	localparam int LEN_W  = $clog2(STORE_BYTES + 1);
	localparam int SUM_W  = LEN_W + 1;
	localparam int QCNT_W = $clog2(QD + 1);
	localparam int QS_W   = QCNT_W + 1;
	localparam int LCNT_W = $clog2(LINE_LIMIT + 1);
	localparam int COL_W  = sbf_pkg::COL_W;
	localparam int BYTE_W = sbf_pkg::BYTE_W;

	sbf_pkg::state_t state_q, state_d;

	logic [IDX_W-1:0]                     oldest_q, oldest_d;
	logic [LEN_W-1:0]                     len_q, len_d;
	logic [QA_W-1:0]                      head_q, head_d;
	logic [QCNT_W-1:0]                    comp_q, comp_d;
	logic [COL_W-1:0]                     col_q, col_d;
	logic [LEN_W-1:0]                     unread_q, unread_d;
	logic                                 ovf_q, ovf_d;
	logic [sbf_pkg::TOTAL_W-1:0]          total_q, total_d;
	logic [sbf_pkg::MAX_LINES_W-1:0]      max_lines_q;
	logic [sbf_pkg::MAX_COLS_W-1:0]       max_cols_q;
	logic [BYTE_W-1:0]                    b_q, b_d;
	logic                                 nl_first_q, nl_first_d;
	logic                                 full_q, full_d;
	logic                                 rd_op_q, rd_op_d;
	logic                                 st_q, st_d;
	logic                                 last_q, last_d;

	logic                                 ov_q;
	logic                                 out_load;
	logic [BYTE_W-1:0]                    o_byte_q;
	logic [LEN_W-1:0]                     o_len_q;
	logic [LEN_W-1:0]                     o_new_q;
	logic [LCNT_W-1:0]                    o_lines_q;
	logic                                 o_ovf_q;
	logic [sbf_pkg::TOTAL_W-1:0]          o_total_q;
	logic                                 o_status_q;

	logic [QCNT_W-1:0]                    lim;
	logic [COL_W-1:0]                     fold;
	logic [IDX_W-1:0]                     oldest_inc;
	logic [QA_W-1:0]                      head_inc;
	logic [SUM_W-1:0]                     rsum;
	logic [IDX_W-1:0]                     rd_addr;
	logic [BYTE_W-1:0]                    rb;

	// put datapath
	logic [BYTE_W-1:0]                    cb;
	logic                                 merge;
	logic [IDX_W-1:0]                     o1;
	logic [LEN_W-1:0]                     l1, l2;
	logic [QA_W-1:0]                      h1;
	logic [QCNT_W-1:0]                    c1, c2;
	logic [SUM_W-1:0]                     psum;
	logic [IDX_W-1:0]                     pos;
	logic [SUM_W-1:0]                     uinc;
	logic [LEN_W-1:0]                     put_unread;
	logic                                 rec_line;
	logic [QS_W-1:0]                      qsum;
	logic [QA_W-1:0]                      qpos;

	// drop datapath
	logic [SUM_W-1:0]                     dsum;
	logic [SUM_W-1:0]                     removed;
	logic [LEN_W-1:0]                     rem;
	logic [LEN_W-1:0]                     d_len;
	logic [IDX_W-1:0]                     d_oldest;
	logic [LEN_W-1:0]                     d_unread;

	always_comb begin
		if ({{QCNT_W{1'b0}}, max_lines_q} > (QCNT_W + sbf_pkg::MAX_LINES_W)'(LINE_LIMIT)) begin
			lim = QCNT_W'(LINE_LIMIT);
		end else begin
			lim = QCNT_W'(max_lines_q);
		end
	end

	always_comb begin
		fold = COL_W'(max_cols_q);
		if (fold != '0 && fold < sbf_pkg::MIN_FOLD) begin
			fold = sbf_pkg::MIN_FOLD;
		end
		if (fold > COL_W'(COL_LIMIT)) begin
			fold = COL_W'(COL_LIMIT);
		end
	end

	assign oldest_inc = (oldest_q == IDX_W'(STORE_BYTES - 1)) ? '0 : oldest_q + 1'b1;
	assign head_inc   = (head_q == QA_W'(QD - 1)) ? '0 : head_q + 1'b1;

	assign rsum    = SUM_W'(oldest_q) + SUM_W'(item.index);
	assign rd_addr = (rsum >= SUM_W'(STORE_BYTES)) ? IDX_W'(rsum - SUM_W'(STORE_BYTES))
		: IDX_W'(rsum);

	always_comb begin
		cb    = nl_first_q ? sbf_pkg::NEWLINE : b_q;
		// a full store drops its oldest byte; a newline there may close the oldest line
		merge = full_q && t_rdata == sbf_pkg::NEWLINE && comp_q != '0 && q_rdata == oldest_q;
		o1    = full_q ? oldest_inc : oldest_q;
		l1    = full_q ? len_q - 1'b1 : len_q;
		h1    = merge ? head_inc : head_q;
		c1    = merge ? comp_q - 1'b1 : comp_q;
		psum  = SUM_W'(o1) + SUM_W'(l1);
		pos   = (psum >= SUM_W'(STORE_BYTES)) ? IDX_W'(psum - SUM_W'(STORE_BYTES))
			: IDX_W'(psum);
		l2    = l1 + 1'b1;
		uinc  = SUM_W'(unread_q) + 1'b1;
		put_unread = (uinc > SUM_W'(l2)) ? l2 : LEN_W'(uinc);
		rec_line = cb == sbf_pkg::NEWLINE && c1 < QCNT_W'(QD);
		qsum  = QS_W'(h1) + QS_W'(c1);
		qpos  = (qsum >= QS_W'(QD)) ? QA_W'(qsum - QS_W'(QD)) : QA_W'(qsum);
		c2    = rec_line ? c1 + 1'b1 : c1;
	end

	always_comb begin
		dsum    = SUM_W'(q_rdata) + ((q_rdata < oldest_q) ? SUM_W'(STORE_BYTES) : '0)
			- SUM_W'(oldest_q);
		removed = dsum + 1'b1;
		rem     = (removed > SUM_W'(len_q)) ? len_q : LEN_W'(removed);
		d_len   = len_q - rem;
		d_oldest = (q_rdata == IDX_W'(STORE_BYTES - 1)) ? '0 : q_rdata + 1'b1;
		d_unread = (unread_q > d_len) ? d_len : unread_q;
	end

	always_comb begin
		if (rd_op_q && !st_q) begin
			rb = (t_rdata == '0) ? sbf_pkg::ZERO_CHAR : t_rdata;
		end else begin
			rb = '0;
		end
	end

	always_comb begin
		state_d    = state_q;
		oldest_d   = oldest_q;
		len_d      = len_q;
		head_d     = head_q;
		comp_d     = comp_q;
		col_d      = col_q;
		unread_d   = unread_q;
		ovf_d      = ovf_q;
		total_d    = total_q;
		b_d        = b_q;
		nl_first_d = nl_first_q;
		full_d     = full_q;
		rd_op_d    = rd_op_q;
		st_d       = st_q;
		last_d     = last_q;
		out_load   = 1'b0;
		item.ready = 1'b0;
		t_we       = 1'b0;
		t_waddr    = pos;
		t_wdata    = cb;
		t_re       = 1'b0;
		t_raddr    = oldest_q;
		q_we       = 1'b0;
		q_waddr    = qpos;
		q_wdata    = pos;
		q_re       = 1'b0;
		q_raddr    = head_q;

		unique case (state_q)
			sbf_pkg::ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					unique case (sbf_pkg::op_t'(item.operation))
						sbf_pkg::OP_APPEND: begin
							total_d    = total_q + 1'b1;
							last_d     = item.last_of_write;
							rd_op_d    = 1'b0;
							st_d       = 1'b0;
							b_d        = item.byte_value;
							nl_first_d = 1'b0;
							if (lim == '0) begin
								state_d = item.last_of_write ? sbf_pkg::ST_EMIT : sbf_pkg::ST_IDLE;
							end else begin
								if (item.byte_value == sbf_pkg::NEWLINE) begin
									col_d = '0;
								end else if (fold != '0 && col_q >= fold) begin
									// fold: a newline goes in ahead of the byte
									col_d      = COL_W'(1);
									nl_first_d = 1'b1;
								end else if (col_q < sbf_pkg::COL_MAX) begin
									col_d = col_q + 1'b1;
								end
								full_d  = len_q == LEN_W'(STORE_BYTES);
								state_d = full_d ? sbf_pkg::ST_FETCH : sbf_pkg::ST_PUT;
							end
						end
						sbf_pkg::OP_READ: begin
							last_d  = 1'b1;
							rd_op_d = 1'b1;
							st_d    = !(LEN_W'(item.index) < len_q);
							t_re    = 1'b1;
							t_raddr = rd_addr;
							state_d = sbf_pkg::ST_EMIT;
						end
						sbf_pkg::OP_CLEAR: begin
							last_d   = 1'b1;
							rd_op_d  = 1'b0;
							st_d     = 1'b0;
							unread_d = '0;
							state_d  = sbf_pkg::ST_EMIT;
						end
						sbf_pkg::OP_NONE: begin
							state_d = sbf_pkg::ST_IDLE;
						end
					endcase
				end
			end
			sbf_pkg::ST_FETCH: begin
				t_re    = 1'b1;
				t_raddr = oldest_q;
				q_re    = 1'b1;
				q_raddr = head_q;
				state_d = sbf_pkg::ST_PUT;
			end
			sbf_pkg::ST_PUT: begin
				if (full_q) begin
					ovf_d = 1'b1;
				end
				t_we     = 1'b1;
				q_we     = rec_line;
				oldest_d = o1;
				len_d    = l2;
				head_d   = h1;
				comp_d   = c2;
				unread_d = put_unread;
				if (nl_first_q) begin
					nl_first_d = 1'b0;
					full_d     = l2 == LEN_W'(STORE_BYTES);
					state_d    = full_d ? sbf_pkg::ST_FETCH : sbf_pkg::ST_PUT;
				end else if (c2 > lim) begin
					state_d = sbf_pkg::ST_DROP_RD;
				end else begin
					state_d = last_q ? sbf_pkg::ST_EMIT : sbf_pkg::ST_IDLE;
				end
			end
			sbf_pkg::ST_DROP_RD: begin
				q_re    = 1'b1;
				q_raddr = head_q;
				state_d = sbf_pkg::ST_DROP;
			end
			sbf_pkg::ST_DROP: begin
				oldest_d = d_oldest;
				len_d    = d_len;
				head_d   = head_inc;
				comp_d   = comp_q - 1'b1;
				ovf_d    = 1'b1;
				unread_d = d_unread;
				if (comp_d > lim) begin
					state_d = sbf_pkg::ST_DROP_RD;
				end else begin
					state_d = last_q ? sbf_pkg::ST_EMIT : sbf_pkg::ST_IDLE;
				end
			end
			sbf_pkg::ST_EMIT: begin
				if (!ov_q || res.ready) begin
					out_load = 1'b1;
					state_d  = sbf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sbf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sbf_pkg::ST_IDLE;
			oldest_q   <= '0;
			len_q      <= '0;
			head_q     <= '0;
			comp_q     <= '0;
			col_q      <= '0;
			unread_q   <= '0;
			ovf_q      <= 1'b0;
			total_q    <= '0;
			nl_first_q <= 1'b0;
			full_q     <= 1'b0;
			rd_op_q    <= 1'b0;
			st_q       <= 1'b0;
			last_q     <= 1'b0;
			ov_q       <= 1'b0;
		end else begin
			state_q    <= state_d;
			oldest_q   <= oldest_d;
			len_q      <= len_d;
			head_q     <= head_d;
			comp_q     <= comp_d;
			col_q      <= col_d;
			unread_q   <= unread_d;
			ovf_q      <= ovf_d;
			total_q    <= total_d;
			nl_first_q <= nl_first_d;
			full_q     <= full_d;
			rd_op_q    <= rd_op_d;
			st_q       <= st_d;
			last_q     <= last_d;
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (res.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_lines_q <= '0;
			max_cols_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sbf_pkg::CFG_MAX_LINES: max_lines_q <= cfg_data[sbf_pkg::MAX_LINES_W-1:0];
				sbf_pkg::CFG_MAX_COLS:  max_cols_q  <= cfg_data[sbf_pkg::MAX_COLS_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		b_q <= b_d;
		if (out_load) begin
			o_byte_q   <= rb;
			o_len_q    <= len_q;
			o_new_q    <= unread_q;
			o_lines_q  <= LCNT_W'(comp_q);
			o_ovf_q    <= ovf_q;
			o_total_q  <= total_q;
			o_status_q <= st_q;
		end
	end

	assign res.valid       = ov_q;
	assign res.read_byte   = o_byte_q;
	assign res.text_length = o_len_q;
	assign res.new_bytes   = o_new_q;
	assign res.line_count  = o_lines_q;
	assign res.overflowed  = o_ovf_q;
	assign res.total_bytes = o_total_q;
	assign res.status      = o_status_q;

endmodule

`default_nettype wire

@@ src/scrollback_line_fold_buffer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake     word
// item     in   valid/ready   operation, byte_value, index, last_of_write
// res      out  valid/ready   read_byte, text_length, new_bytes, line_count, overflowed,
//                             total_bytes, status
// one item at a time through a sequencer around the byte store and the line end queue
// append: accept, then a put per stored byte (a fold puts a newline first), a fetch of the
// oldest byte before a put to a full store, a read and a drop per dropped line, a result
// read, clear: a result; results wait in an output register, only the next result stalls
// reset clears all counters and pointers at once; both memories need no clearing pass

module scrollback_line_fold_buffer #(
	parameter int STORE_BYTES = sbf_pkg::STORE_BYTES_DEF,
	parameter int LINE_LIMIT  = sbf_pkg::LINE_LIMIT_DEF,
	parameter int COL_LIMIT   = sbf_pkg::COL_LIMIT_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [sbf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sbf_pkg::CFG_DATA_W-1:0] cfg_data,
	sbf_in_if.sink                              item,
	sbf_out_if.source                           res
);

	localparam int IDX_W = $clog2(STORE_BYTES);
	localparam int QD    = LINE_LIMIT + 1;
	localparam int QA_W  = $clog2(QD);

	logic                        t_we;
	logic [IDX_W-1:0]            t_waddr;
	logic [sbf_pkg::BYTE_W-1:0]  t_wdata;
	logic                        t_re;
	logic [IDX_W-1:0]            t_raddr;
	logic [sbf_pkg::BYTE_W-1:0]  t_rdata;
	logic                        q_we;
	logic [QA_W-1:0]             q_waddr;
	logic [IDX_W-1:0]            q_wdata;
	logic                        q_re;
	logic [QA_W-1:0]             q_raddr;
	logic [IDX_W-1:0]            q_rdata;

	sbf_ctrl #(
		.STORE_BYTES (STORE_BYTES),
		.LINE_LIMIT  (LINE_LIMIT),
		.COL_LIMIT   (COL_LIMIT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.res       (res),
		.t_we      (t_we),
		.t_waddr   (t_waddr),
		.t_wdata   (t_wdata),
		.t_re      (t_re),
		.t_raddr   (t_raddr),
		.t_rdata   (t_rdata),
		.q_we      (q_we),
		.q_waddr   (q_waddr),
		.q_wdata   (q_wdata),
		.q_re      (q_re),
		.q_raddr   (q_raddr),
		.q_rdata   (q_rdata)
	);

	// circular text store
	sbf_ram #(
		.DEPTH (STORE_BYTES),
		.WIDTH (sbf_pkg::BYTE_W)
	) u_text_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.re    (t_re),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	// positions of line-ending newlines, oldest line at the head
	sbf_ram #(
		.DEPTH (QD),
		.WIDTH (IDX_W)
	) u_line_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.re    (q_re),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

endmodule

`default_nettype wire
